FILE: hw/rtl/sat_pkg.sv
// Package for the set-associative tag table: sizes, operation and status
// codes, the request/response item structs and the memory row layout.
// No dependencies.
package sat_pkg;

  // NUM_SETS must be a power of two; the set index wraps by dropping high bits.
  localparam int NUM_SETS = 256;
  localparam int NUM_WAYS = 4;
  localparam int TAG_BITS = 24;

  localparam int SET_BITS = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_BITS = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INV    = 2'd1;
  localparam logic [1:0] FUNC_FILL   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  set_index;
    logic [23:0] addr;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] way;
  } rsp_t;

  // One memory row holds a whole set: valid bits and tags of all ways.
  typedef struct packed {
    logic [NUM_WAYS-1:0]               valid;
    logic [NUM_WAYS-1:0][TAG_BITS-1:0] tag;
  } row_t;

  // Outcome of scanning one set for a tag and for a free way.
  typedef struct packed {
    logic                hit;
    logic [WAY_BITS-1:0] hit_way;
    logic                free;
    logic [WAY_BITS-1:0] free_way;
  } match_t;

endpackage

FILE: hw/rtl/set_assoc_tag_table.sv
// Set-associative tag table top level: request sequencer around one set-wide
// row memory with read-modify-write. Depends on sat_pkg, sat_ram, sat_way_match.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------
//   req     | in        | req_valid, req_stall | req_t: func, set_index, addr
//   rsp     | out       | rsp_valid, rsp_stall | rsp_t: status, way
//
// Each item reads the set row, then compares all ways and writes the row back if
// it changed; req_stall stays high until that compare step finishes.
// After reset a clearing pass zeroes every one of the NUM_SETS rows (256), with
// req_stall high. A result waits in an output register; the next item is
// taken while it waits, and the compare step holds until the register frees.
module set_assoc_tag_table
  import sat_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

  state_t              state;
  logic [SET_BITS-1:0] clr_addr;
  logic [1:0]          cur_func;
  logic [SET_BITS-1:0] cur_set;
  logic [TAG_BITS-1:0] cur_tag;

  logic                req_take;
  logic                look_done;
  logic                ram_we;
  logic [SET_BITS-1:0] ram_waddr;
  row_t                ram_wdata;
  row_t                rd_row;
  row_t                row_next;
  match_t              match;
  rsp_t                rsp_next;
  logic                row_change;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign look_done = (state == S_LOOK) && (!rsp_valid || !rsp_stall);

  sat_ram #(
    .WIDTH($bits(row_t)),
    .DEPTH(NUM_SETS)
  ) u_row_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (req_take),
    .raddr(req.set_index[SET_BITS-1:0]),
    .rdata(rd_row)
  );

  sat_way_match u_match (
    .row   (rd_row),
    .tag   (cur_tag),
    .result(match)
  );

  always_comb begin
    row_next   = rd_row;
    rsp_next   = '0;
    row_change = 1'b0;
    unique case (cur_func)
      FUNC_INV: begin
        if (match.hit) begin
          row_next.valid[match.hit_way] = 1'b0;
          row_change    = 1'b1;
          rsp_next.status = ST_OK;
          rsp_next.way    = 2'(match.hit_way);
        end else begin
          rsp_next.status = ST_NOTFOUND;
        end
      end
      FUNC_FILL: begin
        if (match.free) begin
          row_next.valid[match.free_way] = 1'b1;
          row_next.tag[match.free_way]   = cur_tag;
          row_change    = 1'b1;
          rsp_next.status = ST_OK;
          rsp_next.way    = 2'(match.free_way);
        end else begin
          rsp_next.status = ST_FULL;
        end
      end
      default: begin
        // Lookup; the unused code behaves the same.
        if (match.hit) begin
          rsp_next.status = ST_OK;
          rsp_next.way    = 2'(match.hit_way);
        end else begin
          rsp_next.status = ST_MISS;
        end
      end
    endcase
  end

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = look_done && row_change;
      ram_waddr = cur_set;
      ram_wdata = row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (look_done) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SET_BITS'(NUM_SETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_take) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          // Hold until the output register is free.
          if (look_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      cur_func <= req.func;
      cur_set  <= req.set_index[SET_BITS-1:0];
      cur_tag  <= req.addr[TAG_BITS-1:0];
    end
    if (look_done) begin
      rsp <= rsp_next;
    end
  end

  a_take_then_look: assert property (@(posedge clk) disable iff (rst)
    req_take |=> state == S_LOOK)
    else $error("accepted item did not move to compare step");

  a_rsp_from_look: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_LOOK))
    else $error("result appeared without a compare step");

  a_look_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) && rsp_valid && rsp_stall |=> state == S_LOOK)
    else $error("compare step finished while output register was full");

  a_fill_sets_valid: assert property (@(posedge clk) disable iff (rst)
    look_done && (cur_func == FUNC_FILL) && match.free |->
      ram_we && ram_wdata.valid[match.free_way])
    else $error("fill did not write a valid way");

  a_inv_clears_valid: assert property (@(posedge clk) disable iff (rst)
    look_done && (cur_func == FUNC_INV) && match.hit |->
      ram_we && !ram_wdata.valid[match.hit_way])
    else $error("invalidate did not clear the matching way");

endmodule

FILE: hw/rtl/sat_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Read data holds while no read is issued. No dependencies.
module sat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/sat_way_match.sv
// Parallel way compare for one set row: lowest valid way holding the tag
// and lowest invalid way. Depends on sat_pkg.
module sat_way_match
  import sat_pkg::*;
(
  input  row_t                row,
  input  logic [TAG_BITS-1:0] tag,
  output match_t              result
);

  always_comb begin
    result = '0;
    // Walk down so the lowest qualifying way wins.
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row.valid[w] && row.tag[w] == tag) begin
        result.hit     = 1'b1;
        result.hit_way = WAY_BITS'(w);
      end
      if (!row.valid[w]) begin
        result.free     = 1'b1;
        result.free_way = WAY_BITS'(w);
      end
    end
  end

endmodule

FILE: sim/set_assoc_tag_table_tb.sv
// Testbench for set_assoc_tag_table: directed and random request traffic, with a
// behavioral tag table that predicts every response and a checker that compares them.
// Depends on sat_pkg and the set_assoc_tag_table RTL.
module set_assoc_tag_table_tb
  import sat_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_SPARE = 2'd3;  // unused code, behaves as a lookup
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 10;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // Predicted table contents, indexed by set and way
  logic                line_valid [NUM_SETS][NUM_WAYS];
  logic [TAG_BITS-1:0] line_tag   [NUM_SETS][NUM_WAYS];

  rsp_t expected_rsp_q[$];
  int   error_count = 0;
  int   cycle_count = 0;
  bit   gap_quiet = 1'b0;
  bit   stall_quiet = 1'b0;

  logic [23:0] addr_pool[12];
  logic [7:0]  hot_sets[8];

  set_assoc_tag_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Apply one request to the predicted table and return the response it yields
  function automatic rsp_t tag_table_access(req_t r);
    rsp_t res;
    int   set_sel;
    int   hit_way;
    int   free_way;
    logic [TAG_BITS-1:0] tag;
    set_sel  = int'(r.set_index) % NUM_SETS;
    tag      = r.addr[TAG_BITS-1:0];
    hit_way  = -1;
    free_way = -1;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (line_valid[set_sel][w] && line_tag[set_sel][w] == tag) hit_way = w;
      if (!line_valid[set_sel][w]) free_way = w;
    end
    res = '0;
    case (r.func)
      FUNC_INV: begin
        if (hit_way >= 0) begin
          line_valid[set_sel][hit_way] = 1'b0;
          res.status = ST_OK;
          res.way    = hit_way[1:0];
        end else begin
          res.status = ST_NOTFOUND;
        end
      end
      FUNC_FILL: begin
        if (free_way >= 0) begin
          line_valid[set_sel][free_way] = 1'b1;
          line_tag[set_sel][free_way]   = tag;
          res.status = ST_OK;
          res.way    = free_way[1:0];
        end else begin
          res.status = ST_FULL;
        end
      end
      default: begin
        if (hit_way >= 0) begin
          res.status = ST_OK;
          res.way    = hit_way[1:0];
        end else begin
          res.status = ST_MISS;
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [1:0] got,
                                 input logic [1:0] want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // Handshake signals are stable around the falling edge: sample there
  always @(negedge clk) begin : check_rsp
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_stall === 1'b0) expected_rsp_q.push_back(tag_table_access(req));
      if (rsp_valid === 1'b1 && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected response, status", rsp.status, 2'd0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.status !== want.status) report_mismatch("status", rsp.status, want.status);
          if (rsp.way !== want.way) report_mismatch("way", rsp.way, want.way);
        end
      end
    end
  end

  // Response backpressure: runs of stall or ready, mostly short, a few long
  initial begin : drive_rsp_stall
    int hold_cnt;
    int r;
    hold_cnt = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_quiet) begin
        rsp_stall <= 1'b0;
        hold_cnt = 0;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          rsp_stall <= 1'b0;
          hold_cnt = $urandom_range(0, 4);
        end else if (r < 95) begin
          rsp_stall <= 1'b1;
          hold_cnt = $urandom_range(0, 2);
        end else begin
          rsp_stall <= 1'b1;
          hold_cnt = $urandom_range(10, 30);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (gap_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Called at a rising edge; returns at the edge where the item is accepted
  task automatic send_req(input logic [1:0] func, input logic [7:0] set_index,
                          input logic [23:0] addr);
    int   gap;
    req_t item;
    item.func      = func;
    item.set_index = set_index;
    item.addr      = addr;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(negedge clk); while (req_stall !== 1'b0);
    @(posedge clk);
  endtask

  // Random request aimed mostly at a few hot sets and a small address pool,
  // so sets fill up, duplicates occur and invalidates find their tags
  task automatic send_random_req(input int fill_w, input int inv_w);
    int          r;
    logic [1:0]  func;
    logic [7:0]  set_index;
    logic [23:0] addr;
    r = $urandom_range(0, 99);
    if (r < fill_w) func = FUNC_FILL;
    else if (r < fill_w + inv_w) func = FUNC_INV;
    else if (r < 95) func = FUNC_LOOKUP;
    else func = FUNC_SPARE;
    if ($urandom_range(0, 9) < 8) set_index = hot_sets[$urandom_range(0, 7)];
    else set_index = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) < 8) addr = addr_pool[$urandom_range(0, 11)];
    else addr = 24'($urandom_range(0, 24'hFFFFFF));
    send_req(func, set_index, addr);
  endtask

  task automatic test_directed_cases();
    send_req(FUNC_LOOKUP, 8'd0, 24'h000000);  // empty set: miss
    send_req(FUNC_INV,    8'd0, 24'hFFFFFF);  // empty set: not found
    send_req(FUNC_FILL,   8'd0, 24'h000000);
    send_req(FUNC_FILL,   8'd0, 24'hFFFFFF);
    send_req(FUNC_FILL,   8'd0, 24'h000000);  // duplicate tag goes to the next way
    send_req(FUNC_FILL,   8'd0, 24'h123456);
    send_req(FUNC_FILL,   8'd0, 24'h654321);  // set full
    send_req(FUNC_LOOKUP, 8'd0, 24'h000000);  // lowest duplicate wins
    send_req(FUNC_SPARE,  8'd0, 24'hFFFFFF);  // acts as lookup, no state change
    send_req(FUNC_INV,    8'd0, 24'h000000);
    send_req(FUNC_LOOKUP, 8'd0, 24'h000000);  // now the second copy
    send_req(FUNC_FILL,   8'd0, 24'hABCDEF);  // reuses the freed way
    send_req(FUNC_INV,    8'd0, 24'h000000);
    send_req(FUNC_INV,    8'd0, 24'h000000);
    send_req(FUNC_FILL,   8'd255, 24'hFFFFFF);
    send_req(FUNC_LOOKUP, 8'd255, 24'hFFFFFF);
    send_req(FUNC_LOOKUP, 8'd254, 24'hFFFFFF);  // neighbor set stays empty
    send_req(FUNC_SPARE,  8'd255, 24'h000000);
    send_req(FUNC_FILL,   8'd255, 24'h800000);
    send_req(FUNC_LOOKUP, 8'd255, 24'h7FFFFF);
    send_req(FUNC_INV,    8'd255, 24'h800000);
    send_req(FUNC_INV,    8'd255, 24'hFFFFFF);
  endtask

  // Four phases: fill heavy, drain heavy, mixed, balanced; with stretches of full rate
  task automatic test_fill_drain_traffic();
    int fill_w[4] = '{60, 25, 40, 35};
    int inv_w[4]  = '{15, 50, 25, 30};
    int phase;
    for (int i = 0; i < 1000; i++) begin
      phase       = i / 250;
      gap_quiet   = (i % 200) >= 170;
      stall_quiet = (i % 300) >= 260;
      send_random_req(fill_w[phase], inv_w[phase]);
    end
    gap_quiet   = 1'b0;
    stall_quiet = 1'b0;
  endtask

  task automatic test_back_to_back();
    gap_quiet   = 1'b1;
    stall_quiet = 1'b1;
    for (int i = 0; i < 350; i++) send_random_req(35, 30);
    gap_quiet   = 1'b0;
    stall_quiet = 1'b0;
  endtask

  initial begin
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        line_valid[s][w] = 1'b0;
        line_tag[s][w]   = '0;
      end
    end
    addr_pool[0] = 24'h000000;
    addr_pool[1] = 24'hFFFFFF;
    for (int i = 2; i < 12; i++) addr_pool[i] = 24'($urandom());
    addr_pool[3] = addr_pool[2] ^ 24'h000001;  // near-miss tag
    hot_sets[0] = 8'd0;
    hot_sets[1] = 8'd255;
    for (int i = 2; i < 8; i++) hot_sets[i] = 8'($urandom_range(0, 255));

    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_fill_drain_traffic();
    test_back_to_back();

    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
